// ----- sv/ihc_pkg.sv -----
package ihc_pkg;

	// Header geometry.
	localparam int HDR_BYTES = 20;
	localparam int IDX_W     = $clog2(HDR_BYTES);
	localparam int SUM_W     = 20;
	localparam int BYTE_W    = 8;
	localparam int ADDR_W    = 32;
	localparam int VERDICT_W = 4;

	// Byte positions of the fields that are kept.
	localparam logic [IDX_W-1:0] IDX_VER_LEN   = IDX_W'(0);
	localparam logic [IDX_W-1:0] IDX_FRAG_HI   = IDX_W'(6);
	localparam logic [IDX_W-1:0] IDX_FRAG_LO   = IDX_W'(7);
	localparam logic [IDX_W-1:0] IDX_PROTO     = IDX_W'(9);
	localparam logic [IDX_W-1:0] IDX_SRC_FIRST = IDX_W'(12);
	localparam logic [IDX_W-1:0] IDX_SRC_LAST  = IDX_W'(15);
	localparam logic [IDX_W-1:0] IDX_DST_FIRST = IDX_W'(16);
	localparam logic [IDX_W-1:0] IDX_DST_LAST  = IDX_W'(19);
	localparam logic [IDX_W-1:0] IDX_LAST      = IDX_W'(HDR_BYTES - 1);

	// Header field values.
	localparam logic [3:0]        IP_VERSION   = 4'd4;
	localparam logic [3:0]        IP_IHL       = 4'd5;
	localparam int                FRAG_MF_BIT  = 13;
	localparam logic [12:0]       FRAG_OFS_MASK = 13'h1FFF;
	localparam logic [7:0]        PROTO_ICMP   = 8'd1;
	localparam logic [7:0]        PROTO_TCP    = 8'd6;
	localparam logic [7:0]        PROTO_UDP    = 8'd17;
	localparam logic [ADDR_W-1:0] BCAST_ADDR   = 32'hFFFF_FFFF;
	localparam logic [15:0]       SUM_GOOD     = 16'hFFFF;

	typedef enum logic [VERDICT_W-1:0] {
		VERDICT_ICMP      = 4'd0,
		VERDICT_TCP       = 4'd1,
		VERDICT_UDP       = 4'd2,
		VERDICT_VERSION   = 4'd3,
		VERDICT_OPTIONS   = 4'd4,
		VERDICT_FRAGMENT  = 4'd5,
		VERDICT_CHECKSUM  = 4'd6,
		VERDICT_NOT_OURS  = 4'd7,
		VERDICT_PROTO_UNS = 4'd8
	} verdict_t;

	// Fields collected while a header streams in.
	typedef struct packed {
		logic [BYTE_W-1:0] ver_len;
		logic [15:0]       frag;
		logic [BYTE_W-1:0] proto;
		logic [ADDR_W-1:0] src;
		logic [ADDR_W-1:0] dst;
		logic [SUM_W-1:0]  sum;
	} hdr_fields_t;

	// Parser to judge: a complete header is ready this cycle.
	typedef struct packed {
		logic        done;
		hdr_fields_t hdr;
	} hdr_result_t;

endpackage

// ----- sv/ihc_in_if.sv -----
interface ihc_in_if;
	import ihc_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] hdr_byte;
	logic              first_byte;

	modport source (output valid, output hdr_byte, output first_byte, input ready);
	modport sink   (input valid, input hdr_byte, input first_byte, output ready);

endinterface

// ----- sv/ihc_out_if.sv -----
interface ihc_out_if;
	import ihc_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [VERDICT_W-1:0] verdict;
	logic [BYTE_W-1:0]    protocol_num;
	logic [ADDR_W-1:0]    src_addr;
	logic [ADDR_W-1:0]    dst_addr;

	modport source (output valid, output verdict, output protocol_num,
		output src_addr, output dst_addr, input ready);
	modport sink   (input valid, input verdict, input protocol_num,
		input src_addr, input dst_addr, output ready);

endinterface

// ----- sv/ihc_parse.sv -----
module ihc_parse (
	input  logic                 clk,
	input  logic                 arst_n,
	ihc_in_if.sink               hdr_in,
	input  logic                 res_free,
	output ihc_pkg::hdr_result_t result
);
	import ihc_pkg::*;

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              first_s1;

	logic              parse_active_q;
	logic [IDX_W-1:0]  byte_index_q;
	logic [BYTE_W-1:0] high_half_q;
	hdr_fields_t       hdr_q;

	logic              act;
	logic              last;
	logic              done;
	logic              advance;
	logic [IDX_W-1:0]  idx;
	logic [BYTE_W-1:0] high_n;
	hdr_fields_t       hdr_n;

	// The input stage moves on unless it holds a finished header and the result is blocked.
	assign advance      = !done || res_free;
	assign hdr_in.ready = advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= hdr_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (hdr_in.valid && advance) begin
			byte_s1  <= hdr_in.hdr_byte;
			first_s1 <= hdr_in.first_byte;
		end
	end

	// Next header state for the byte in the input register.
	always_comb begin
		act     = first_s1 || parse_active_q;
		idx     = first_s1 ? '0 : byte_index_q;
		hdr_n   = hdr_q;
		high_n  = high_half_q;
		if (first_s1) begin
			hdr_n.sum = '0;
		end
		// Even bytes hold the upper half of a word; odd bytes complete it into the sum.
		if (!idx[0]) begin
			high_n = byte_s1;
		end else begin
			hdr_n.sum = hdr_n.sum + SUM_W'({high_half_q, byte_s1});
		end
		case (idx) inside
			IDX_VER_LEN:                    hdr_n.ver_len = byte_s1;
			IDX_FRAG_HI:                    hdr_n.frag[15:8] = byte_s1;
			IDX_FRAG_LO:                    hdr_n.frag[7:0] = byte_s1;
			IDX_PROTO:                      hdr_n.proto = byte_s1;
			[IDX_SRC_FIRST:IDX_SRC_LAST]:   hdr_n.src = {hdr_q.src[ADDR_W-BYTE_W-1:0], byte_s1};
			[IDX_DST_FIRST:IDX_DST_LAST]:   hdr_n.dst = {hdr_q.dst[ADDR_W-BYTE_W-1:0], byte_s1};
			default: ;
		endcase
		last = (idx >= IDX_LAST);
		done = valid_s1 && act && last;
	end

	assign result.done = done;
	assign result.hdr  = hdr_n;

	// Parse control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parse_active_q <= 1'b0;
			byte_index_q   <= '0;
		end else if (valid_s1 && advance && act) begin
			parse_active_q <= !last;
			byte_index_q   <= last ? '0 : idx + IDX_W'(1);
		end
	end

	// Collected header fields.
	always_ff @(posedge clk) begin
		if (valid_s1 && advance && act) begin
			hdr_q       <= hdr_n;
			high_half_q <= high_n;
		end
	end

`ifndef SYNTHESIS
	a_index_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		byte_index_q <= IDX_LAST)
		else $error("byte index beyond the header");

	a_idle_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!parse_active_q |-> byte_index_q == '0)
		else $error("byte index not cleared while idle");

	a_stall_holds_byte: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(byte_s1) && $stable(first_s1))
		else $error("stalled header byte was lost");
`endif

endmodule

// ----- sv/ihc_judge.sv -----
module ihc_judge (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ihc_pkg::hdr_result_t        result,
	input  logic [ihc_pkg::ADDR_W-1:0]  local_addr,
	output logic                        res_free,
	ihc_out_if.source                   res_out
);
	import ihc_pkg::*;

	logic        out_valid_q;
	logic        load;
	logic [16:0] fold1;
	logic [16:0] fold2;
	verdict_t    verdict;

	assign res_free = !out_valid_q || res_out.ready;
	assign load     = result.done && res_free;

	// End-around-carry fold of the sum, then the checks in priority order.
	always_comb begin
		fold1 = {1'b0, result.hdr.sum[15:0]} + 17'(result.hdr.sum[SUM_W-1:16]);
		fold2 = {1'b0, fold1[15:0]} + 17'(fold1[16]);
		if (result.hdr.ver_len[7:4] != IP_VERSION) begin
			verdict = VERDICT_VERSION;
		end else if (result.hdr.ver_len[3:0] != IP_IHL) begin
			verdict = VERDICT_OPTIONS;
		end else if (result.hdr.frag[FRAG_MF_BIT]
				|| (result.hdr.frag[12:0] & FRAG_OFS_MASK) != '0) begin
			verdict = VERDICT_FRAGMENT;
		end else if (fold2[15:0] != SUM_GOOD) begin
			verdict = VERDICT_CHECKSUM;
		end else if (result.hdr.dst != BCAST_ADDR && result.hdr.dst != local_addr) begin
			verdict = VERDICT_NOT_OURS;
		end else if (result.hdr.proto == PROTO_ICMP) begin
			verdict = VERDICT_ICMP;
		end else if (result.hdr.proto == PROTO_TCP) begin
			verdict = VERDICT_TCP;
		end else if (result.hdr.proto == PROTO_UDP) begin
			verdict = VERDICT_UDP;
		end else begin
			verdict = VERDICT_PROTO_UNS;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_free) begin
			out_valid_q <= result.done;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_out.verdict      <= verdict;
			res_out.protocol_num <= result.hdr.proto;
			res_out.src_addr     <= result.hdr.src;
			res_out.dst_addr     <= result.hdr.dst;
		end
	end

	assign res_out.valid = out_valid_q;

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !res_out.ready |-> !load)
		else $error("pending result overwritten");

	a_verdict_code: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> res_out.valid && res_out.verdict <= VERDICT_PROTO_UNS)
		else $error("result not shown after a finished header");
`endif

endmodule

// ----- sv/ipv4_header_check_unit.sv -----
// IPv4 header checker.
// hdr_in takes one header byte per transaction, in network order, with
// first_byte set on byte 0; a start flag in mid-header drops the old parse.
// Bytes that arrive while no header is open, and bytes after the twentieth,
// are dropped without a result.
// res_out carries one transaction per complete 20-byte header: a verdict
// code plus the protocol, source and destination fields of that header.
// cfg_we/cfg_wdata load the local station address; write it only while idle.
// Throughput is one byte per cycle while hdr_in is ready; in the input
// register the ones' complement add and field capture happen, and a
// finished header is checked into the result register in that same step.
// The last byte is taken into the input register, its verdict then into the result register.
// When res_out stalls, the result is held; hdr_in keeps taking bytes until a
// second finished header waits in the input register behind it.
// Reset clears the parse, the result valid flag and the local address to zero.
module ipv4_header_check_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [ihc_pkg::ADDR_W-1:0]  cfg_wdata,
	ihc_in_if.sink                      hdr_in,
	ihc_out_if.source                   res_out
);
	import ihc_pkg::*;

	logic [ADDR_W-1:0] local_addr_q;
	logic              res_free;
	hdr_result_t       result;

	// Local address register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_addr_q <= '0;
		end else if (cfg_we) begin
			local_addr_q <= cfg_wdata;
		end
	end

	ihc_parse u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.hdr_in   (hdr_in),
		.res_free (res_free),
		.result   (result)
	);

	ihc_judge u_judge (
		.clk        (clk),
		.arst_n     (arst_n),
		.result     (result),
		.local_addr (local_addr_q),
		.res_free   (res_free),
		.res_out    (res_out)
	);

endmodule
